>>> rtl/ksel_pkg.sv
`default_nettype none

package ksel_pkg;

    localparam int MAX_STAGGER  = 32;
    localparam int K_TILE_LIMIT = 64;
    localparam int LINE_BYTES   = 128;
    localparam int SHIFT_LIMIT  = 5;
    // Tile counts above this cannot change any decision.
    localparam int TILE_SAT     = 65536;

    localparam int DVD_W = 32;
    localparam int DVS_W = 12;
    localparam int ACC_W = 48;
    localparam int MB_W  = 17;

    typedef enum logic [1:0] {
        CFG_CUS  = 2'd0,
        CFG_DIES = 2'd1,
        CFG_L2   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] rows_m;
        logic [31:0] cols_n;
        logic [31:0] depth_k;
        logic [15:0] batch_count;
        logic [10:0] tile_m;
        logic [10:0] tile_n;
        logic [10:0] tile_k;
        logic [1:0]  nontemporal_flags;
        logic [3:0]  bytes_a;
        logic [3:0]  bytes_b;
        logic [15:0] sk_grid;
        logic signed [11:0] wgm;
    } item_t;

    typedef struct packed {
        logic [10:0] num_compute_units;
        logic [4:0]  num_dies;
        logic [31:0] l2_capacity_bytes;
    } cfg_t;

    typedef struct packed {
        logic       stagger_mapping;
        logic [5:0] stagger_count;
        logic [2:0] stride_shift;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } div_rsp_t;

    // Smallest shift that makes one K step span a cache line, saturating.
    function automatic logic [2:0] calc_shift(input logic [14:0] kbytes);
        logic [2:0]  s;
        logic [19:0] w;
        s = 3'(SHIFT_LIMIT);
        for (int i = SHIFT_LIMIT - 1; i >= 0; i--) begin
            w = {5'b0, kbytes} << i;
            if (w >= 20'(LINE_BYTES)) begin
                s = 3'(i);
            end
        end
        return s;
    endfunction

    // Largest power of two not above tk >> shift, at least one, capped.
    function automatic logic [5:0] calc_max_s(input logic [6:0] tk, input logic [2:0] sh);
        logic [6:0] v;
        logic [6:0] p;
        v = tk >> sh;
        p = 7'd1;
        for (int i = 1; i < 7; i++) begin
            if (7'(1 << i) <= v) begin
                p = 7'(1 << i);
            end
        end
        if (p > 7'(MAX_STAGGER)) begin
            p = 7'(MAX_STAGGER);
        end
        return 6'(p);
    endfunction

    // Round a count up to a power of two (at least two), capped by mx.
    function automatic logic [5:0] round_cnt(input logic [5:0] cnt, input logic [5:0] mx);
        logic [6:0] p;
        p = 7'd2;
        for (int i = 0; i < 5; i++) begin
            if (p < 7'(cnt)) begin
                p = p << 1;
            end
        end
        if (p > 7'(mx)) begin
            p = 7'(mx);
        end
        return 6'(p);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ksel_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ksel_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ksel_pkg::div_req_t  req,
    output ksel_pkg::div_rsp_t       rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic [ksel_pkg::DVD_W-1:0]   quo_reg;
    logic [ksel_pkg::DVS_W-1:0]   rem_reg;
    logic [ksel_pkg::DVS_W-1:0]   dvs_reg;
    logic [ksel_pkg::DVS_W:0]     trial;
    logic                         fits;
    logic [ksel_pkg::DVS_W-1:0]   rem_step;

    always_comb begin
        trial    = {rem_reg, quo_reg[ksel_pkg::DVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_step = fits ? ksel_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                        : trial[ksel_pkg::DVS_W-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(ksel_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ksel_pkg::DVD_W-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/ksel_core.sv
`default_nettype none

// Sequencer and datapath: walks one launch through the shared divider and
// the shared multiplier, then holds the result until it is taken.
module ksel_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire ksel_pkg::item_t    item,
    input  wire ksel_pkg::cfg_t     cfg,
    output logic                    idle,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ksel_pkg::res_t          res
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_DTM   = 17'h00002,
        ST_DTN   = 17'h00004,
        ST_DTK   = 17'h00008,
        ST_MTILE = 17'h00010,
        ST_CHK   = 17'h00020,
        ST_DCPD  = 17'h00040,
        ST_DPT   = 17'h00080,
        ST_DV0   = 17'h00100,
        ST_DU1   = 17'h00200,
        ST_DREM  = 17'h00400,
        ST_MUL   = 17'h00800,
        ST_WSCHK = 17'h01000,
        ST_DGM   = 17'h02000,
        ST_DGN   = 17'h04000,
        ST_DEC   = 17'h08000,
        ST_FIN   = 17'h10000
    } state_t;

    localparam int AW = ksel_pkg::ACC_W;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic [3:0] mstep_reg, mstep_next;

    ksel_pkg::item_t it_reg, it_next;
    logic [31:0] tm_reg, tm_next, tn_reg, tn_next, tk_reg, tk_next;
    logic [16:0] tiles_reg, tiles_next;
    logic [10:0] cpd_reg, cpd_next, pt_reg, pt_next;
    logic [11:0] u_reg, u_next, v_reg, v_next;
    logic [AW-1:0] p_reg, p_next, acon_reg, acon_next, bcon_reg, bcon_next;
    logic [AW-1:0] t1_reg, t1_next;
    logic [31:0] gm_reg, gm_next, gn_reg, gn_next;
    logic       map_reg, map_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] sh_reg, sh_next;

    ksel_pkg::div_req_t dreq;
    ksel_pkg::div_rsp_t drsp;
    logic               div_start;

    ksel_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    logic        pos;
    logic [11:0] aw_val, u0, lm, ln, lsel;
    logic [31:0] big_u, big_v;
    logic [4:0]  dies_eff;
    logic [3:0]  bmin;
    logic [14:0] kbytes;
    logic [2:0]  shift;
    logic [5:0]  max_s, l2v, rc;
    logic        l2map, die_map, close_c, asym_c, zero_in, rm;
    logic [31:0] cdiv_val, dvd;
    logic [11:0] dvs;
    logic [AW-1:0] mul_a, win, lose;
    logic [ksel_pkg::MB_W-1:0] mul_b;
    logic [AW+ksel_pkg::MB_W-1:0] mul_full;
    logic [AW-1:0] mul_p;
    logic [11:0] lmax, lmin;

    always_comb begin
        pos      = !it_reg.wgm[11];
        aw_val   = it_reg.wgm[11] ? 12'(~it_reg.wgm + 12'sd1) : 12'(it_reg.wgm);
        big_u    = pos ? tn_reg : tm_reg;
        big_v    = pos ? tm_reg : tn_reg;
        u0       = (32'(aw_val) < big_u) ? aw_val : big_u[11:0];
        dies_eff = (cfg.num_dies == 5'd0) ? 5'd1 : cfg.num_dies;
        bmin     = (it_reg.bytes_a < it_reg.bytes_b) ? it_reg.bytes_a : it_reg.bytes_b;
        kbytes   = 15'(it_reg.tile_k) * 15'(bmin);
        shift    = ksel_pkg::calc_shift(kbytes);
        max_s    = ksel_pkg::calc_max_s(tk_reg[6:0], shift);
        lm       = pos ? v_reg : u_reg;
        ln       = pos ? u_reg : v_reg;
        l2map    = !(bcon_reg > acon_reg);
        lsel     = l2map ? ln : lm;
        l2v      = (lsel < 12'(max_s)) ? 6'(lsel) : max_s;
        die_map  = !(gm_reg > gn_reg);
        win      = (acon_reg > bcon_reg) ? acon_reg : bcon_reg;
        lose     = (acon_reg > bcon_reg) ? bcon_reg : acon_reg;
        close_c  = {1'b0, win} < {lose, 1'b0};
        lmax     = (lm > ln) ? lm : ln;
        lmin     = (lm > ln) ? ln : lm;
        asym_c   = {1'b0, lmax} > {lmin, 1'b0};
        zero_in  = (item.rows_m == 32'd0) || (item.cols_n == 32'd0) ||
                   (item.depth_k == 32'd0) || (item.batch_count == 16'd0) ||
                   (item.tile_m == 11'd0) || (item.tile_n == 11'd0) ||
                   (item.tile_k == 11'd0);
    end

    // Divider operand selection.
    always_comb begin
        dvd = '0;
        dvs = '0;
        case (state_reg)
            ST_DTM:  begin dvd = it_reg.rows_m;  dvs = 12'(it_reg.tile_m); end
            ST_DTN:  begin dvd = it_reg.cols_n;  dvs = 12'(it_reg.tile_n); end
            ST_DTK:  begin dvd = it_reg.depth_k; dvs = 12'(it_reg.tile_k); end
            ST_DCPD: begin dvd = 32'(cfg.num_compute_units); dvs = 12'(dies_eff); end
            ST_DPT:  begin dvd = 32'(tiles_reg); dvs = 12'(dies_eff); end
            ST_DV0:  begin dvd = 32'(pt_reg); dvs = u0; end
            ST_DU1:  begin dvd = 32'(pt_reg); dvs = v_reg; end
            ST_DREM: begin dvd = 32'(pt_reg); dvs = u_reg; end
            ST_DGM:  begin dvd = tm_reg; dvs = lm; end
            ST_DGN:  begin dvd = tn_reg; dvs = ln; end
            default: begin dvd = '0; dvs = '0; end
        endcase
        dreq.start    = div_start;
        dreq.dividend = dvd;
        dreq.divisor  = dvs;
        cdiv_val = (dvs == 12'd0) ? 32'd0
                 : drsp.quot + 32'((drsp.rem != 12'd0) ? 1 : 0);
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = p_reg;
        mul_b = '0;
        if (state_reg == ST_MTILE) begin
            mul_a = (tm_reg > 32'(ksel_pkg::TILE_SAT)) ? AW'(ksel_pkg::TILE_SAT) : AW'(tm_reg);
            mul_b = (tn_reg > 32'(ksel_pkg::TILE_SAT)) ? 17'(ksel_pkg::TILE_SAT) : tn_reg[16:0];
        end else begin
            case (mstep_reg)
                4'd0:    begin mul_a = pos ? AW'(ln) : AW'(1); mul_b = 17'(ln); end
                4'd1:    mul_b = 17'(it_reg.tile_m);
                4'd2:    mul_b = 17'(it_reg.bytes_a);
                4'd3:    begin mul_a = pos ? AW'(1) : AW'(lm); mul_b = 17'(lm); end
                4'd4:    mul_b = 17'(it_reg.tile_n);
                4'd5:    mul_b = 17'(it_reg.bytes_b);
                4'd6:    begin mul_a = l2map ? AW'(l2v) : AW'(1); mul_b = 17'(lm); end
                4'd7:    mul_b = 17'(it_reg.tile_m);
                4'd8:    mul_b = 17'(it_reg.bytes_a);
                4'd9:    begin mul_a = l2map ? AW'(1) : AW'(l2v); mul_b = 17'(ln); end
                4'd10:   mul_b = 17'(it_reg.tile_n);
                4'd11:   mul_b = 17'(it_reg.bytes_b);
                4'd13:   begin mul_a = t1_reg; mul_b = 17'(it_reg.tile_k); end
                4'd14:   mul_b = 17'd20;
                4'd15:   begin mul_a = AW'(cfg.l2_capacity_bytes); mul_b = 17'd19; end
                default: begin mul_a = p_reg; mul_b = '0; end
            endcase
        end
        mul_full = {{ksel_pkg::MB_W{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};
        mul_p    = mul_full[AW-1:0];
    end

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        mstep_next  = mstep_reg;
        it_next     = it_reg;
        tm_next     = tm_reg;
        tn_next     = tn_reg;
        tk_next     = tk_reg;
        tiles_next  = tiles_reg;
        cpd_next    = cpd_reg;
        pt_next     = pt_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        p_next      = p_reg;
        acon_next   = acon_reg;
        bcon_next   = bcon_reg;
        t1_next     = t1_reg;
        gm_next     = gm_reg;
        gn_next     = gn_reg;
        map_next    = map_reg;
        cnt_next    = cnt_reg;
        sh_next     = sh_reg;
        div_start   = 1'b0;
        rm          = 1'b0;
        rc          = '0;

        if (state_reg == ST_DTM || state_reg == ST_DTN || state_reg == ST_DTK ||
            state_reg == ST_DCPD || state_reg == ST_DPT || state_reg == ST_DV0 ||
            state_reg == ST_DU1 || state_reg == ST_DREM || state_reg == ST_DGM ||
            state_reg == ST_DGN) begin
            div_start   = !issued_reg;
            issued_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    it_next = item;
                    if (zero_in) begin
                        map_next   = 1'b0;
                        cnt_next   = '0;
                        sh_next    = '0;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_DTM;
                    end
                end
            end
            ST_DTM: if (drsp.done) begin
                tm_next = cdiv_val; issued_next = 1'b0; state_next = ST_DTN;
            end
            ST_DTN: if (drsp.done) begin
                tn_next = cdiv_val; issued_next = 1'b0; state_next = ST_DTK;
            end
            ST_DTK: if (drsp.done) begin
                tk_next = cdiv_val; issued_next = 1'b0; state_next = ST_MTILE;
            end
            ST_MTILE: begin
                tiles_next = (mul_p > AW'(ksel_pkg::TILE_SAT)) ? 17'(ksel_pkg::TILE_SAT)
                                                               : mul_p[16:0];
                state_next = ST_CHK;
            end
            ST_CHK: begin
                map_next   = 1'b0;
                cnt_next   = '0;
                sh_next    = '0;
                state_next = ST_FIN;
                if (it_reg.batch_count != 16'd1 || tk_reg > 32'(ksel_pkg::K_TILE_LIMIT) ||
                    17'(it_reg.sk_grid) > tiles_reg || max_s == 6'd1) begin
                    state_next = ST_FIN;
                end else if (it_reg.nontemporal_flags[0] || it_reg.nontemporal_flags[1]) begin
                    map_next = !it_reg.nontemporal_flags[0];
                    cnt_next = max_s;
                    sh_next  = shift;
                end else if (it_reg.wgm != 12'sd0) begin
                    state_next = ST_DCPD;
                end
            end
            ST_DCPD: if (drsp.done) begin
                cpd_next = drsp.quot[10:0]; issued_next = 1'b0; state_next = ST_DPT;
            end
            ST_DPT: if (drsp.done) begin
                pt_next = (cdiv_val < 32'(cpd_reg)) ? cdiv_val[10:0] : cpd_reg;
                issued_next = 1'b0;
                state_next  = ST_DV0;
            end
            ST_DV0: if (drsp.done) begin
                u_next = u0;
                v_next = (cdiv_val < big_v) ? cdiv_val[11:0] : big_v[11:0];
                issued_next = 1'b0;
                state_next  = ((cdiv_val == 32'd0) || (big_v == 32'd0)) ? ST_DREM : ST_DU1;
            end
            ST_DU1: if (drsp.done) begin
                if (cdiv_val < big_u) begin
                    if (cdiv_val[11:0] > u_reg) u_next = cdiv_val[11:0];
                end else if (big_u[11:0] > u_reg) begin
                    u_next = big_u[11:0];
                end
                issued_next = 1'b0;
                state_next  = ST_DREM;
            end
            ST_DREM: if (drsp.done) begin
                if (drsp.rem != 12'd0) begin
                    v_next = (32'(v_reg) + 32'd1 < big_v) ? v_reg + 12'd1 : big_v[11:0];
                end
                issued_next = 1'b0;
                mstep_next  = '0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                mstep_next = mstep_reg + 4'd1;
                case (mstep_reg)
                    4'd2:    acon_next = mul_p;
                    4'd5:    bcon_next = mul_p;
                    4'd8:    t1_next   = mul_p;
                    4'd12:   t1_next   = t1_reg + p_reg;
                    4'd15:   t1_next   = mul_p;
                    default: p_next    = mul_p;
                endcase
                if (mstep_reg == 4'd15) begin
                    state_next = ST_WSCHK;
                end
            end
            ST_WSCHK: begin
                state_next = ST_FIN;
                map_next   = 1'b0;
                cnt_next   = '0;
                sh_next    = '0;
                if (p_reg > t1_reg) begin
                    state_next = ST_FIN;
                end else if (l2v == max_s) begin
                    map_next = l2map;
                    cnt_next = max_s;
                    sh_next  = shift;
                end else begin
                    state_next = ST_DGM;
                end
            end
            ST_DGM: if (drsp.done) begin
                gm_next = cdiv_val; issued_next = 1'b0; state_next = ST_DGN;
            end
            ST_DGN: if (drsp.done) begin
                gn_next = cdiv_val; issued_next = 1'b0; state_next = ST_DEC;
            end
            ST_DEC: begin
                if (l2map == die_map) begin
                    rm = l2map; rc = max_s;
                end else if (close_c && asym_c) begin
                    rm = die_map; rc = max_s;
                end else begin
                    rm = l2map; rc = l2v;
                end
                rc = ksel_pkg::round_cnt(rc, max_s);
                if (rc <= 6'd2) begin
                    map_next = 1'b0; cnt_next = '0; sh_next = '0;
                end else begin
                    map_next = rm; cnt_next = rc; sh_next = shift;
                end
                state_next = ST_FIN;
            end
            ST_FIN: if (res_ready) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            mstep_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            mstep_reg  <= mstep_next;
        end
    end

    always_ff @(posedge aclk) begin
        it_reg    <= it_next;
        tm_reg    <= tm_next;
        tn_reg    <= tn_next;
        tk_reg    <= tk_next;
        tiles_reg <= tiles_next;
        cpd_reg   <= cpd_next;
        pt_reg    <= pt_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        p_reg     <= p_next;
        acon_reg  <= acon_next;
        bcon_reg  <= bcon_next;
        t1_reg    <= t1_next;
        gm_reg    <= gm_next;
        gn_reg    <= gn_next;
        map_reg   <= map_next;
        cnt_reg   <= cnt_next;
        sh_reg    <= sh_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);
    assign res.stagger_mapping = map_reg;
    assign res.stagger_count   = cnt_reg;
    assign res.stride_shift    = sh_reg;

`ifndef SYNTHESIS
    // A finished count is zero or a single power of two.
    a_cnt_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> $onehot0(cnt_reg))
        else $error("stagger count is not a power of two");

    // The disabled answer clears every field.
    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && cnt_reg == 6'd0) |-> (!map_reg && sh_reg == 3'd0))
        else $error("disabled answer has nonzero fields");

    // A divide is never launched twice for one step.
    a_single_start: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |=> !dreq.start)
        else $error("divider started on consecutive cycles");
`endif

endmodule

`default_nettype wire

>>> rtl/k_stagger_select_top.sv
`default_nettype none

// K-stagger selector. Each input word describes one matrix-multiply launch;
// the block answers with one output word holding the stagger direction, the
// stagger count (zero when staggering is off, otherwise a power of two up to
// 32) and the stride shift. Work runs through one serial divider (one
// quotient bit per cycle) and one shared 48x17 multiplier under a small
// sequencer; an empty problem or zero tile takes the shortest path, and
// the full decision (ten divisions and sixteen multiply steps) the longest.
// s_tready is high only while the sequencer is idle. A finished result
// sits in an output register, so the next word is accepted while the
// previous result still waits on m_tready. The three configuration
// registers (compute units, dies, cache bytes per die) are written
// through the cfg_ channel, which is always ready, and must only change
// while no word is in flight.
module k_stagger_select_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] rows_m, [63:32] cols_n, [95:64] depth_k, [111:96] batch_count,
    // [122:112] tile_m, [133:123] tile_n, [144:134] tile_k,
    // [146:145] nontemporal_flags, [150:147] bytes_a, [154:151] bytes_b,
    // [170:155] sk_grid, [182:171] wgm, [183] zero
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] stagger_mapping, [6:1] stagger_count, [9:7] stride_shift, [15:10] zero
    output logic [15:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    ksel_pkg::item_t item;
    ksel_pkg::cfg_t  cfg_reg, cfg_next;
    ksel_pkg::res_t  res, out_reg, out_next;
    logic core_idle, res_valid, res_ready;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        item.rows_m            = s_tdata[31:0];
        item.cols_n            = s_tdata[63:32];
        item.depth_k           = s_tdata[95:64];
        item.batch_count       = s_tdata[111:96];
        item.tile_m            = s_tdata[122:112];
        item.tile_n            = s_tdata[133:123];
        item.tile_k            = s_tdata[144:134];
        item.nontemporal_flags = s_tdata[146:145];
        item.bytes_a           = s_tdata[150:147];
        item.bytes_b           = s_tdata[154:151];
        item.sk_grid           = s_tdata[170:155];
        item.wgm               = s_tdata[182:171];
    end

    // Configuration writes; an index past the register list is dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ksel_pkg::CFG_CUS:  cfg_next.num_compute_units = cfg_data[10:0];
                ksel_pkg::CFG_DIES: cfg_next.num_dies          = cfg_data[4:0];
                ksel_pkg::CFG_L2:   cfg_next.l2_capacity_bytes = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    ksel_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .item      (item),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register frees up when its word is taken.
    always_comb begin
        res_ready      = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg                 <= 1'b0;
            cfg_reg.num_compute_units     <= 11'd304;
            cfg_reg.num_dies              <= 5'd8;
            cfg_reg.l2_capacity_bytes     <= 32'd4194304;
        end else begin
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign s_tready  = core_idle;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b0, out_reg.stride_shift, out_reg.stagger_count,
                        out_reg.stagger_mapping};

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;

    // Clock and the single reset at the start of the run.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #5 aclk = ~aclk;

    // Input channel: one launch description per word.
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    // Result channel: one stagger choice per word.
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    // Configuration write channel.
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    k_stagger_select_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Expected stagger choices, oldest first, plus the predictor's copy of
    // the configuration registers.
    class stagger_board;
        ksel_pkg::res_t pending[$];
        logic [10:0] cus = 11'd304;
        logic [4:0]  dies = 5'd8;
        logic [31:0] l2 = 32'd4194304;
        int          errors = 0;

        function longint unsigned cdiv(longint unsigned a, longint unsigned b);
            if (b == 0) return 0;
            return a / b + ((a % b) != 0);
        endfunction

        function longint unsigned mn(longint unsigned a, longint unsigned b);
            return a < b ? a : b;
        endfunction

        function longint unsigned mx(longint unsigned a, longint unsigned b);
            return a > b ? a : b;
        endfunction

        function ksel_pkg::res_t choose_stagger(ksel_pkg::item_t it);
            ksel_pkg::res_t r;
            longint unsigned nd, cpd, tm, tn, tk, tiles, split, kb, sh, ms, p;
            longint unsigned aw, pt, lm, ln, ac, bc, lmap, lval, ws, gm, gn, dmap;
            longint unsigned rmap, rcnt, win, lose;
            longint signed w;
            r = '0;
            w = $signed(it.wgm);
            if (it.rows_m == 0 || it.cols_n == 0 || it.depth_k == 0 || it.batch_count == 0)
                return r;
            if (it.tile_m == 0 || it.tile_n == 0 || it.tile_k == 0) return r;
            nd = (dies == 0) ? 1 : dies;
            cpd = cus / nd;
            tm = cdiv(it.rows_m, it.tile_m);
            tn = cdiv(it.cols_n, it.tile_n);
            tk = cdiv(it.depth_k, it.tile_k);
            tiles = tm * tn;
            split = cdiv(it.sk_grid, tiles);
            if (it.batch_count != 1 || tk > 64 || split > 1) return r;
            kb = it.tile_k * mn(it.bytes_a, it.bytes_b);
            sh = 0;
            while ((kb << sh) < 128 && sh < 5) sh++;
            ms = tk >> sh;
            p = 1;
            while (p * 2 <= ms) p <<= 1;
            ms = mn(p, ksel_pkg::MAX_STAGGER);
            if (ms == 1) return r;
            r.stride_shift = sh;
            r.stagger_count = ms;
            if (it.nontemporal_flags[0]) return r;
            if (it.nontemporal_flags[1]) begin
                r.stagger_mapping = 1'b1;
                return r;
            end
            r = '0;
            if (w == 0) return r;
            aw = (w < 0) ? -w : w;
            pt = (it.sk_grid > tiles) ? cdiv(it.sk_grid, nd) : cdiv(tiles, nd);
            pt = mn(pt, cpd);
            if (w > 0) begin
                ln = mn(aw, tn);
                lm = mn(cdiv(pt, ln), tm);
                while (lm * ln < pt && ln < tn) ln++;
                if (ln != 0 && pt % ln != 0) lm = mn(lm + 1, tm);
                ac = ln * ln * it.tile_m * it.bytes_a;
                bc = lm * it.tile_n * it.bytes_b;
            end else begin
                lm = mn(aw, tm);
                ln = mn(cdiv(pt, lm), tn);
                while (lm * ln < pt && lm < tm) lm++;
                if (lm != 0 && pt % lm != 0) ln = mn(ln + 1, tn);
                ac = ln * it.tile_m * it.bytes_a;
                bc = lm * lm * it.tile_n * it.bytes_b;
            end
            lmap = (bc > ac) ? 0 : 1;
            lval = (lmap == 0) ? mn(lm, tm) : mn(ln, tn);
            lval = mn(lval, ms);
            if (lmap == 0)
                ws = it.tile_k * (lm * it.tile_m * it.bytes_a
                     + mn(lval, lm) * ln * it.tile_n * it.bytes_b);
            else
                ws = it.tile_k * (mn(lval, ln) * lm * it.tile_m * it.bytes_a
                     + ln * it.tile_n * it.bytes_b);
            if (ws * 20 > longint'(l2) * 19) return r;
            if (lval == ms) begin
                r.stagger_mapping = lmap;
                r.stagger_count = ms;
                r.stride_shift = sh;
                return r;
            end
            gm = cdiv(tm, lm);
            gn = cdiv(tn, ln);
            dmap = (gm > gn) ? 0 : 1;
            if (lmap == dmap) begin
                rmap = lmap;
                rcnt = ms;
            end else begin
                win = mx(ac, bc);
                lose = mn(ac, bc);
                if (win < 2 * lose && mx(lm, ln) > 2 * mn(lm, ln)) begin
                    rmap = dmap;
                    rcnt = ms;
                end else begin
                    rmap = lmap;
                    rcnt = lval;
                end
            end
            p = 2;
            while (p < rcnt) p <<= 1;
            rcnt = mn(p, ms);
            if (rcnt <= 2) return r;
            r.stagger_mapping = rmap;
            r.stagger_count = rcnt;
            r.stride_shift = sh;
            return r;
        endfunction

        function void note_launch(ksel_pkg::item_t it);
            pending.insert(pending.size(), choose_stagger(it));
        endfunction

        function void check_choice(logic [15:0] word);
            ksel_pkg::res_t got, exp_r;
            got.stagger_mapping = word[0];
            got.stagger_count = word[6:1];
            got.stride_shift = word[9:7];
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.stagger_mapping !== exp_r.stagger_mapping)
                $display("%0t: stagger_mapping expected %0d actual %0d", $time,
                         exp_r.stagger_mapping, got.stagger_mapping);
            if (got.stagger_count !== exp_r.stagger_count)
                $display("%0t: stagger_count expected %0d actual %0d", $time,
                         exp_r.stagger_count, got.stagger_count);
            if (got.stride_shift !== exp_r.stride_shift)
                $display("%0t: stride_shift expected %0d actual %0d", $time,
                         exp_r.stride_shift, got.stride_shift);
            if (got !== exp_r || word[15:10] !== 6'd0) begin
                if (word[15:10] !== 6'd0)
                    $display("%0t: padding expected 0 actual %h", $time, word[15:10]);
                errors++;
            end
        endfunction
    endclass

    stagger_board board = new();

    // Idle percentages of the two sides, changed by phase.
    int send_idle = 35;
    int recv_idle = 52;
    int quiet_cycles = 0;
    localparam int WATCHDOG = 20000;

    // Receiver: random back-pressure, and every accepted word is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_choice(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: counts cycles in which no word moves on any of the three channels.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Lays the launch fields out on the data bus, first field lowest.
    function automatic logic [183:0] pack_launch(ksel_pkg::item_t it);
        return {1'b0, it.wgm, it.sk_grid, it.bytes_b, it.bytes_a, it.nontemporal_flags,
                it.tile_k, it.tile_n, it.tile_m, it.batch_count, it.depth_k,
                it.cols_n, it.rows_m};
    endfunction

    // Sends one launch word after a random gap and notes it once accepted.
    // The valid stays up between words sent back to back.
    task automatic send_launch(ksel_pkg::item_t it);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_launch(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_launch(it);
    endtask

    // Waits until every expected word has come back, then lets the
    // longest decision time pass so the block is surely idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(ksel_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            ksel_pkg::CFG_CUS:  board.cus = val[10:0];
            ksel_pkg::CFG_DIES: board.dies = val[4:0];
            default:            board.l2 = val;
        endcase
        @(posedge aclk);
    endtask

    // Random launch, mostly shaped so the full decision path is taken:
    // batch one, at most 64 K tiles, and mostly a grid of at most 300.
    function automatic ksel_pkg::item_t random_launch();
        ksel_pkg::item_t it;
        int sel;
        it.rows_m = $urandom_range(1, 8192);
        it.cols_n = $urandom_range(1, 8192);
        it.tile_m = $urandom_range(1, 8) * 32;
        it.tile_n = $urandom_range(1, 8) * 32;
        it.tile_k = 1 << $urandom_range(0, 7);
        it.depth_k = $urandom_range(1, 64) * it.tile_k - $urandom_range(0, 1);
        if (it.depth_k == 0) it.depth_k = 1;
        it.batch_count = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : 16'd1;
        it.nontemporal_flags = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 2'd0;
        it.bytes_a = $urandom_range(1, 8);
        it.bytes_b = $urandom_range(1, 8);
        it.sk_grid = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 300);
        it.wgm = $urandom_range(0, 2048) - 1024;
        sel = $urandom_range(19);
        // Noise: arbitrary sizes, tile sizes, element sizes and wgm, including zero sizes.
        if (sel == 0) begin
            it.rows_m = $urandom;
            it.cols_n = $urandom;
            it.depth_k = $urandom;
            it.tile_m = $urandom_range(0, 1024);
            it.tile_n = $urandom_range(0, 1024);
            it.tile_k = $urandom_range(0, 1024);
            it.bytes_a = $urandom_range(0, 15);
            it.bytes_b = $urandom_range(0, 15);
            it.wgm = $urandom;
        end else if (sel == 1) begin
            it.tile_k = $urandom_range(1, 1024);
            it.bytes_a = $urandom_range(0, 8);
        end
        return it;
    endfunction

    function automatic ksel_pkg::item_t base_launch();
        ksel_pkg::item_t it;
        it = '0;
        it.rows_m = 2048;
        it.cols_n = 2048;
        it.depth_k = 4096;
        it.batch_count = 1;
        it.tile_m = 128;
        it.tile_n = 128;
        it.tile_k = 64;
        it.bytes_a = 2;
        it.bytes_b = 2;
        it.sk_grid = 0;
        it.wgm = 8;
        return it;
    endfunction

    task automatic directed_set();
        ksel_pkg::item_t it;
        // Empty problem in each size and in the batch count.
        for (int f = 0; f < 4; f++) begin
            it = base_launch();
            case (f)
                0: it.rows_m = 0;
                1: it.cols_n = 0;
                2: it.depth_k = 0;
                default: it.batch_count = 0;
            endcase
            send_launch(it);
        end
        // Zero tile size in each dimension.
        for (int f = 0; f < 3; f++) begin
            it = base_launch();
            if (f == 0) it.tile_m = 0;
            else if (f == 1) it.tile_n = 0;
            else it.tile_k = 0;
            send_launch(it);
        end
        // Non-temporal hints, zero mapping, column-major mapping and extremes.
        for (int f = 0; f < 4; f++) begin
            it = base_launch();
            it.nontemporal_flags = f;
            send_launch(it);
        end
        it = base_launch(); it.wgm = 0; send_launch(it);
        it = base_launch(); it.wgm = -1024; send_launch(it);
        it = base_launch(); it.wgm = 1024; send_launch(it);
        it = base_launch(); it.wgm = -1; send_launch(it);
        // Zero element size: the stride shift saturates.
        it = base_launch(); it.bytes_a = 0; it.tile_k = 16; send_launch(it);
        it = base_launch(); it.bytes_b = 15; it.bytes_a = 15; send_launch(it);
        // Field maxima, a large batch and a grid that splits K.
        it = base_launch();
        it.rows_m = '1; it.cols_n = '1; it.depth_k = '1;
        it.tile_m = 1024; it.tile_n = 1024; it.tile_k = 1024;
        it.sk_grid = 16'hFFFF;
        send_launch(it);
        it = base_launch(); it.batch_count = 16'hFFFF; send_launch(it);
        it = base_launch(); it.rows_m = 128; it.cols_n = 128; it.sk_grid = 5;
        send_launch(it);
        it = base_launch(); it.rows_m = 1; it.cols_n = 1; it.depth_k = 1;
        it.tile_m = 1; it.tile_n = 1; it.tile_k = 1; it.bytes_a = 1; it.bytes_b = 1;
        send_launch(it);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: reset configuration, sender lightly idle.
        directed_set();
        repeat (200) send_launch(random_launch());
        drain();

        // Phase two: extremes of the registers, idling swapped.
        send_idle = 52;
        recv_idle = 35;
        write_reg(ksel_pkg::CFG_CUS, 32'd1024);
        write_reg(ksel_pkg::CFG_DIES, 32'd0);
        write_reg(ksel_pkg::CFG_L2, 32'hFFFF_FFFF);
        directed_set();
        repeat (200) send_launch(random_launch());
        drain();

        write_reg(ksel_pkg::CFG_CUS, 32'd1);
        write_reg(ksel_pkg::CFG_DIES, 32'd16);
        write_reg(ksel_pkg::CFG_L2, 32'd0);
        repeat (100) send_launch(random_launch());
        drain();

        // Phase three: no idling on either side, mid-range settings.
        send_idle = 0;
        recv_idle = 0;
        write_reg(ksel_pkg::CFG_CUS, $urandom_range(1, 1024));
        write_reg(ksel_pkg::CFG_DIES, $urandom_range(1, 16));
        write_reg(ksel_pkg::CFG_L2, $urandom_range(65536, 8388608));
        repeat (300) send_launch(random_launch());
        drain();

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
